[design/setl_pkg.sv]
// Shared types, constants and helpers for the shared/exclusive ticket lock.
`timescale 1ns / 1ps

package setl_pkg;

  localparam int SLOTS   = 16;
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int NUM_W   = 64;
  localparam int GRANT_W = 16;

  // An exclusive ticket needs two more counter values above this bound.
  localparam logic [NUM_W-1:0] MAX_EXCL_COUNTER = 64'hFFFF_FFFF_FFFF_FFFD;

  typedef enum logic [2:0] {
    CMD_GET_SHARED     = 3'd0,
    CMD_GET_EXCLUSIVE  = 3'd1,
    CMD_RELEASE        = 3'd2,
    CMD_REISSUE_SHARED = 3'd3,
    CMD_REISSUE_EXCL   = 3'd4,
    CMD_QUERY          = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_HELD  = 2'd2,
    ST_EXHAUSTED = 2'd3
  } status_t;

  // How the result word is assembled once the scan is done.
  typedef enum logic [2:0] {
    KIND_PLAIN,
    KIND_GET,
    KIND_RELEASE,
    KIND_REISSUE,
    KIND_QUERY
  } kind_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_DONE
  } fsm_t;

  // Per-cell write and scan controls.
  typedef struct packed {
    logic set;   // write number, mark valid
    logic clr;   // drop valid
    logic drop;  // released slot: live only for the old minimum
  } cell_ctl_t;

  // Accumulator that travels down the cell chain.
  typedef struct packed {
    logic             any;
    logic [NUM_W-1:0] min;
    logic [SLOTS-1:0] mask;
    logic             larger;
    logic             old_any;
    logic [NUM_W-1:0] old_min;
  } scan_t;

  // Fit a per-slot mask to the 16-bit grant field.
  function automatic logic [GRANT_W-1:0] to_grant(input logic [SLOTS-1:0] m);
    logic [SLOTS+GRANT_W-1:0] ext;
    ext = {{GRANT_W{1'b0}}, m};
    return ext[GRANT_W-1:0];
  endfunction

endpackage

[design/setl_cell.sv]
// One ticket holder cell: stores a slot and folds it into the passing scan word.
`timescale 1ns / 1ps

module setl_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  setl_pkg::cell_ctl_t            ctl,
  input  logic [setl_pkg::NUM_W-1:0]     wr_num,
  input  logic [setl_pkg::NUM_W-1:0]     cmp_val,
  input  logic [setl_pkg::SLOTS-1:0]     self_bit,
  input  setl_pkg::scan_t                tok_in,
  output setl_pkg::scan_t                tok_out,
  output logic                           valid,
  output logic [setl_pkg::NUM_W-1:0]     number
);

  logic                       valid_r;
  logic [setl_pkg::NUM_W-1:0] number_r;
  setl_pkg::scan_t            tok_r;
  setl_pkg::scan_t            tok_nxt;
  logic                       live;
  logic                       old_live;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.set) begin
      valid_r <= 1'b1;
    end else if (ctl.clr) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.set) begin
      number_r <= wr_num;
    end
    tok_r <= tok_nxt;
  end

  assign live     = valid_r & ~ctl.drop;
  assign old_live = valid_r | ctl.drop;

  always_comb begin
    tok_nxt = tok_in;
    // new minimum and its holders
    if (live && (!tok_in.any || number_r < tok_in.min)) begin
      tok_nxt.any  = 1'b1;
      tok_nxt.min  = number_r;
      tok_nxt.mask = self_bit;
    end else if (live && number_r == tok_in.min) begin
      tok_nxt.mask = tok_in.mask | self_bit;
    end
    // minimum before a release
    if (old_live && (!tok_in.old_any || number_r < tok_in.old_min)) begin
      tok_nxt.old_any = 1'b1;
      tok_nxt.old_min = number_r;
    end
    if (live && number_r > cmp_val) begin
      tok_nxt.larger = 1'b1;
    end
  end

  assign tok_out = tok_r;
  assign valid   = valid_r;
  assign number  = number_r;

endmodule

[design/shared_exclusive_ticket_lock_core.sv]
// Top level of the shared/exclusive ticket lock: command decode, cell chain, result word.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid / in_stall): one command word carries in_cmd and
//   in_slot. Result channel (out_valid / out_stall): exactly one result word per
//   command, in command order. A word moves on an edge with valid high and
//   stall low.
//   The table lives in a chain of SLOTS cells. An accepted command updates the
//   table at once, then a scan word walks the chain one cell per cycle and
//   collects the lowest live number, its holders and whether a larger number
//   exists. The walk sets the timing: a result word is loaded into the output
//   register once the walk has passed the last cell and that register is free,
//   and the next command is taken the cycle after that load, so the block takes
//   no new command while one is still being scanned or waiting to load.
//   The output register decouples the sides: while the receiver stalls, the
//   block may already accept and scan the next command; it then holds that
//   finished result until the output register frees up.
//   Reset (rst_n low, synchronous) empties the table, zeroes the ticket
//   counter, drops any command in flight and clears out_valid.
module shared_exclusive_ticket_lock_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [3:0]  in_slot,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [3:0]  out_ticket_slot,
  output logic [63:0] out_ticket_value,
  output logic        out_is_running,
  output logic        out_waiting_behind,
  output logic [15:0] out_grant_mask
);

  localparam int SLOTS  = setl_pkg::SLOTS;
  localparam int SLOT_W = setl_pkg::SLOT_W;
  localparam int NUM_W  = setl_pkg::NUM_W;

  // Control state
  setl_pkg::fsm_t       state_r;
  setl_pkg::fsm_t       state_nxt;
  logic [SLOT_W-1:0]    cnt_r;
  logic [SLOT_W-1:0]    cnt_nxt;
  logic [NUM_W-1:0]     counter_r;
  logic [NUM_W-1:0]     counter_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;

  // Command held for the scan
  setl_pkg::kind_t      kind_r;
  setl_pkg::status_t    status_r;
  logic [3:0]           slot_out_r;
  logic [SLOT_W-1:0]    idx_r;
  logic [NUM_W-1:0]     val_r;
  logic [SLOTS-1:0]     drop_r;

  // Decode of the incoming word
  setl_pkg::kind_t      kind_nxt;
  setl_pkg::status_t    status_nxt;
  logic [3:0]           slot_out_nxt;
  logic [SLOT_W-1:0]    idx_nxt;
  logic [NUM_W-1:0]     val_nxt;
  logic [SLOTS-1:0]     drop_nxt;
  logic [SLOTS-1:0]     set_vec;
  logic                 acc;
  logic                 load;

  // Result register
  logic [1:0]           o_status_r;
  logic [3:0]           o_slot_r;
  logic [NUM_W-1:0]     o_value_r;
  logic                 o_run_r;
  logic                 o_wait_r;
  logic [15:0]          o_grant_r;
  logic [1:0]           o_status_nxt;
  logic [NUM_W-1:0]     o_value_nxt;
  logic                 o_run_nxt;
  logic                 o_wait_nxt;
  logic [15:0]          o_grant_nxt;

  // Cell chain
  setl_pkg::scan_t      tok [SLOTS+1];
  setl_pkg::cell_ctl_t  ctl [SLOTS];
  logic [SLOTS-1:0]     valid_vec;
  logic [NUM_W-1:0]     number_vec [SLOTS];

  logic                 full;
  logic [SLOT_W-1:0]    free_idx;
  logic [SLOT_W-1:0]    s_idx;
  logic                 held;
  logic                 exhausted;
  setl_pkg::scan_t      res;

  assign acc  = in_valid && !in_stall;
  assign load = (state_r == setl_pkg::FSM_DONE) && (!out_valid_r || !out_stall);

  assign s_idx     = SLOT_W'(in_slot);
  assign held      = (32'(in_slot) < SLOTS) && valid_vec[s_idx];
  assign full      = &valid_vec;
  assign exhausted = counter_r > setl_pkg::MAX_EXCL_COUNTER;

  // Lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_vec[i]) begin
        free_idx = SLOT_W'(i);
      end
    end
  end

  // Decode the command; table writes land on the accepting edge.
  always_comb begin
    kind_nxt     = setl_pkg::KIND_PLAIN;
    status_nxt   = setl_pkg::ST_OK;
    slot_out_nxt = in_slot;
    idx_nxt      = s_idx;
    val_nxt      = '0;
    drop_nxt     = '0;
    set_vec      = '0;
    counter_nxt  = counter_r;
    unique case (setl_pkg::cmd_t'(in_cmd))
      setl_pkg::CMD_GET_SHARED, setl_pkg::CMD_GET_EXCLUSIVE: begin
        slot_out_nxt = '0;
        if (full) begin
          status_nxt = setl_pkg::ST_FULL;
        end else if (in_cmd == setl_pkg::CMD_GET_EXCLUSIVE && exhausted) begin
          status_nxt = setl_pkg::ST_EXHAUSTED;
        end else begin
          kind_nxt          = setl_pkg::KIND_GET;
          idx_nxt           = free_idx;
          slot_out_nxt      = 4'(free_idx);
          set_vec[free_idx] = 1'b1;
          if (in_cmd == setl_pkg::CMD_GET_EXCLUSIVE) begin
            val_nxt     = counter_r + NUM_W'(1);
            counter_nxt = counter_r + NUM_W'(2);
          end else begin
            val_nxt = counter_r;
          end
        end
      end
      setl_pkg::CMD_RELEASE: begin
        if (!held) begin
          status_nxt = setl_pkg::ST_NOT_HELD;
        end else begin
          kind_nxt        = setl_pkg::KIND_RELEASE;
          drop_nxt[s_idx] = 1'b1;
        end
      end
      setl_pkg::CMD_REISSUE_SHARED, setl_pkg::CMD_REISSUE_EXCL: begin
        if (!held) begin
          status_nxt = setl_pkg::ST_NOT_HELD;
        end else if (in_cmd == setl_pkg::CMD_REISSUE_EXCL && exhausted) begin
          status_nxt = setl_pkg::ST_EXHAUSTED;
        end else begin
          kind_nxt       = setl_pkg::KIND_REISSUE;
          set_vec[s_idx] = 1'b1;
          if (in_cmd == setl_pkg::CMD_REISSUE_EXCL) begin
            val_nxt     = counter_r + NUM_W'(1);
            counter_nxt = counter_r + NUM_W'(2);
          end else begin
            val_nxt = counter_r;
          end
        end
      end
      setl_pkg::CMD_QUERY: begin
        if (!held) begin
          status_nxt = setl_pkg::ST_NOT_HELD;
        end else begin
          kind_nxt = setl_pkg::KIND_QUERY;
          val_nxt  = number_vec[s_idx];
        end
      end
      default: begin
        // unused codes: plain ok word, slot echoed
      end
    endcase
  end

  // Cell controls: writes only on the accepting edge, drop held through the scan.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      ctl[i].set  = acc && set_vec[i];
      ctl[i].clr  = acc && drop_nxt[i];
      ctl[i].drop = drop_r[i];
    end
  end

  assign tok[0] = '0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    setl_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl[g]),
      .wr_num  (val_nxt),
      .cmp_val (val_r),
      .self_bit(SLOTS'(1) << g),
      .tok_in  (tok[g]),
      .tok_out (tok[g+1]),
      .valid   (valid_vec[g]),
      .number  (number_vec[g])
    );
  end

  assign res = tok[SLOTS];

  // Sequencer: idle, walk the chain, wait for the output register.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      setl_pkg::FSM_IDLE: begin
        if (acc) begin
          state_nxt = setl_pkg::FSM_SCAN;
          cnt_nxt   = '0;
        end
      end
      setl_pkg::FSM_SCAN: begin
        cnt_nxt = cnt_r + SLOT_W'(1);
        if (cnt_r == SLOT_W'(SLOTS - 1)) begin
          state_nxt = setl_pkg::FSM_DONE;
        end
      end
      setl_pkg::FSM_DONE: begin
        if (load) begin
          state_nxt = setl_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_nxt = setl_pkg::FSM_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != setl_pkg::FSM_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= setl_pkg::FSM_IDLE;
      cnt_r     <= '0;
      counter_r <= '0;
      drop_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      // advance the counter and the drop marks only for an accepted word
      if (acc) begin
        counter_r <= counter_nxt;
        drop_r    <= drop_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      kind_r     <= kind_nxt;
      status_r   <= status_nxt;
      slot_out_r <= slot_out_nxt;
      idx_r      <= idx_nxt;
      val_r      <= val_nxt;
    end
  end

  // Assemble the result word from the finished scan.
  always_comb begin
    o_status_nxt = status_r;
    o_value_nxt  = '0;
    o_run_nxt    = 1'b0;
    o_wait_nxt   = 1'b0;
    o_grant_nxt  = '0;
    unique case (kind_r)
      setl_pkg::KIND_GET: begin
        o_value_nxt = val_r;
        o_run_nxt   = res.mask[idx_r];
        o_wait_nxt  = res.larger;
        o_grant_nxt = setl_pkg::to_grant(res.mask & (SLOTS'(1) << idx_r));
      end
      setl_pkg::KIND_RELEASE: begin
        // grant only when the lowest number moved
        if (res.any && res.min != res.old_min) begin
          o_grant_nxt = setl_pkg::to_grant(res.mask);
        end
      end
      setl_pkg::KIND_REISSUE: begin
        o_value_nxt = val_r;
        o_run_nxt   = res.mask[idx_r];
        o_wait_nxt  = res.larger;
        o_grant_nxt = setl_pkg::to_grant(res.mask);
      end
      setl_pkg::KIND_QUERY: begin
        o_value_nxt = val_r;
        o_run_nxt   = res.mask[idx_r];
        o_wait_nxt  = res.larger;
      end
      default: begin
        // status-only word
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      o_status_r <= o_status_nxt;
      o_slot_r   <= slot_out_r;
      o_value_r  <= o_value_nxt;
      o_run_r    <= o_run_nxt;
      o_wait_r   <= o_wait_nxt;
      o_grant_r  <= o_grant_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = o_status_r;
  assign out_ticket_slot    = o_slot_r;
  assign out_ticket_value   = o_value_r;
  assign out_is_running     = o_run_r;
  assign out_waiting_behind = o_wait_r;
  assign out_grant_mask     = o_grant_r;

  // Checks
  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> (state_r == setl_pkg::FSM_SCAN))
    else $error("accepted word did not start a scan");

  a_get_adds_one_holder: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && kind_nxt == setl_pkg::KIND_GET) |=>
      ($countones(valid_vec) == $countones($past(valid_vec)) + 1))
    else $error("get did not add exactly one holder");

  a_counter_moves_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    !acc |=> $stable(counter_r))
    else $error("ticket counter moved without a command");

  a_result_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == setl_pkg::FSM_DONE))
    else $error("result word appeared without a finished scan");

endmodule
